>>> hdl/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared constants, breakpoint ROM and inter-stage types of the thermistor
// table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

  localparam int ROM_POINTS            = 32;
  localparam int DEFAULT_TABLE_ENTRIES = 32;
  localparam int ADC_W                 = 10;
  localparam int TEMP_W                = 16;
  localparam int NUM_W                 = ADC_W + TEMP_W;
  localparam int ROM_IDX_W             = $clog2(ROM_POINTS);

  // Breakpoint converter codes, ascending.
  localparam logic [ADC_W-1:0] ROM_ADC [ROM_POINTS] = '{
    10'd250, 10'd275, 10'd300, 10'd325, 10'd350, 10'd375, 10'd400, 10'd425,
    10'd450, 10'd475, 10'd500, 10'd525, 10'd550, 10'd575, 10'd600, 10'd625,
    10'd650, 10'd675, 10'd700, 10'd725, 10'd750, 10'd775, 10'd784, 10'd825,
    10'd850, 10'd875, 10'd900, 10'd925, 10'd937, 10'd950, 10'd975, 10'd1000
  };

  // Breakpoint temperatures, unsigned Q8.8, ascending.
  localparam logic [TEMP_W-1:0] ROM_TEMP [ROM_POINTS] = '{
    16'd358,   16'd1024,  16'd1638,  16'd2253,  16'd2842,  16'd3430,  16'd3994,  16'd4557,
    16'd5120,  16'd5683,  16'd6246,  16'd6835,  16'd7424,  16'd8013,  16'd8627,  16'd9242,
    16'd9907,  16'd10573, 16'd11290, 16'd12058, 16'd12851, 16'd13747, 16'd14080, 16'd15744,
    16'd16947, 16'd18304, 16'd19942, 16'd21939, 16'd23117, 16'd24576, 16'd28467, 16'd35712
  };

  // Segment selected for one request.
  typedef struct packed {
    logic [TEMP_W-1:0] t0;
    logic [TEMP_W-1:0] dt;
    logic [ADC_W-1:0]  dx;
    logic [ADC_W-1:0]  da;
    logic              oor;
  } seg_t;

  // Rounded numerator ready for division.
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [ADC_W-1:0]  da;
    logic [TEMP_W-1:0] t0;
    logic              oor;
  } prod_t;

  // Division result with the base temperature.
  typedef struct packed {
    logic [TEMP_W-1:0] quo;
    logic [TEMP_W-1:0] t0;
    logic              oor;
  } quot_t;

endpackage

`default_nettype wire

>>> hdl/thermistor_table_interpolator.sv
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Converts a 10-bit thermistor converter sample into an unsigned Q8.8
// temperature by piecewise linear interpolation over a 32-point breakpoint
// ROM, of which the first TABLE_ENTRIES points (at most 32) are in use. An
// exact breakpoint gives its table temperature; a sample below the first or
// above the last breakpoint in use is clamped to that end temperature and
// flagged with out_of_range. Interpolated values round to nearest, halves
// up. A request is taken in every cycle in which the output side is free,
// and its result passes through two search stages, one multiply stage,
// sixteen divider stages (one quotient bit each) and the output register.
// The divider depth sets the latency. A stall on the result side freezes
// the whole pipeline and holds off new requests; nothing is dropped or
// repeated. The block keeps no state between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_table_interpolator #(
  parameter int TABLE_ENTRIES = tti_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [tti_pkg::ADC_W-1:0]  adc_sample_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [tti_pkg::TEMP_W-1:0]     temperature_q8_8_o,
  output logic                           out_of_range_o
);

  localparam int N_USE = (TABLE_ENTRIES < tti_pkg::ROM_POINTS) ? TABLE_ENTRIES
                                                               : tti_pkg::ROM_POINTS;
  localparam logic [tti_pkg::TEMP_W-1:0] TEMP_LO = tti_pkg::ROM_TEMP[0];
  localparam logic [tti_pkg::TEMP_W-1:0] TEMP_HI = tti_pkg::ROM_TEMP[N_USE-1];

  // Advance every stage together unless a held result is still waiting.
  logic advance;
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  logic           seg_valid;
  tti_pkg::seg_t  seg;
  logic           prod_valid;
  tti_pkg::prod_t prod;
  logic           quot_valid;
  tti_pkg::quot_t quot;

  tti_seg_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .in_valid_i   (in_valid_i),
    .adc_sample_i (adc_sample_i),
    .seg_valid_o  (seg_valid),
    .seg_o        (seg)
  );

  tti_interp_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .seg_valid_i  (seg_valid),
    .seg_i        (seg),
    .prod_valid_o (prod_valid),
    .prod_o       (prod)
  );

  tti_div_pipe u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .quot_valid_o (quot_valid),
    .quot_o       (quot)
  );

  // Output register: add the base temperature; hold while stalled.
  logic                      out_valid_q;
  logic [tti_pkg::TEMP_W-1:0] temp_d, temp_q;
  logic                      oor_q;

  assign temp_d = quot.t0 + quot.quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= quot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      temp_q <= temp_d;
      oor_q  <= quot.oor;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign temperature_q8_8_o = temp_q;
  assign out_of_range_o     = oor_q;

  // A clamped result is always one of the two end temperatures.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      (temperature_q8_8_o == TEMP_LO) || (temperature_q8_8_o == TEMP_HI))
    else $error("clamped result is not an end temperature");

  // Every result lies within the span of the table in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temperature_q8_8_o >= TEMP_LO) && (temperature_q8_8_o <= TEMP_HI))
    else $error("result outside the table temperature span");

  // A request is refused only while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o || quot_valid))
    else $error("request refused with no held result");

endmodule

`default_nettype wire

>>> hdl/tti_seg_search.sv
// ----------------------------------------------------------------------------
// tti_seg_search
// Two stages: locate the bracketing breakpoint, then fetch the segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_seg_search #(
  parameter int TABLE_ENTRIES = tti_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     advance_i,
  input  wire logic                     in_valid_i,
  input  wire logic [tti_pkg::ADC_W-1:0] adc_sample_i,
  output logic                          seg_valid_o,
  output tti_pkg::seg_t                 seg_o
);

  localparam int N_USE = (TABLE_ENTRIES < tti_pkg::ROM_POINTS) ? TABLE_ENTRIES
                                                               : tti_pkg::ROM_POINTS;
  localparam int IDX_W = $clog2(N_USE + 1);

  // Stage A: count breakpoints below the sample (thermometer edge).
  logic [N_USE:0]               lt_ext;
  logic [IDX_W-1:0]             cnt_d, cnt_q;
  logic [tti_pkg::ADC_W-1:0]    x_q;
  logic                         vld_a_q;

  always_comb begin
    lt_ext = '0;
    for (int i = 0; i < N_USE; i++) begin
      lt_ext[i] = tti_pkg::ROM_ADC[i] < adc_sample_i;
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int i = 0; i < N_USE; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) begin
        cnt_d = cnt_d | IDX_W'(i + 1);
      end
    end
  end

  // Stage B: pick the segment, or a flat segment for direct results.
  logic [tti_pkg::ROM_IDX_W-1:0] hi_idx, lo_idx;
  logic                          exact, below, above;
  tti_pkg::seg_t                 seg_d, seg_q;
  logic                          seg_valid_q;

  always_comb begin
    above  = (cnt_q == IDX_W'(N_USE));
    hi_idx = above ? tti_pkg::ROM_IDX_W'(N_USE - 1) : tti_pkg::ROM_IDX_W'(cnt_q);
    lo_idx = (cnt_q == '0) ? '0 : tti_pkg::ROM_IDX_W'(cnt_q - IDX_W'(1));
    exact  = !above && (x_q == tti_pkg::ROM_ADC[hi_idx]);
    below  = (cnt_q == '0) && !exact;
    if (exact || below || above) begin
      seg_d.t0 = tti_pkg::ROM_TEMP[hi_idx];
      seg_d.dt = '0;
      seg_d.dx = '0;
      seg_d.da = tti_pkg::ADC_W'(1);
    end else begin
      seg_d.t0 = tti_pkg::ROM_TEMP[lo_idx];
      seg_d.dt = tti_pkg::ROM_TEMP[hi_idx] - tti_pkg::ROM_TEMP[lo_idx];
      seg_d.dx = x_q - tti_pkg::ROM_ADC[lo_idx];
      seg_d.da = tti_pkg::ROM_ADC[hi_idx] - tti_pkg::ROM_ADC[lo_idx];
    end
    seg_d.oor = below || above;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q     <= 1'b0;
      seg_valid_q <= 1'b0;
    end else if (advance_i) begin
      vld_a_q     <= in_valid_i;
      seg_valid_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      x_q   <= adc_sample_i;
      cnt_q <= cnt_d;
      seg_q <= seg_d;
    end
  end

  assign seg_valid_o = seg_valid_q;
  assign seg_o       = seg_q;

endmodule

`default_nettype wire

>>> hdl/tti_interp_mul.sv
// ----------------------------------------------------------------------------
// tti_interp_mul
// One stage: scale the temperature step and add the rounding bias.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_interp_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire logic          seg_valid_i,
  input  wire tti_pkg::seg_t seg_i,
  output logic               prod_valid_o,
  output tti_pkg::prod_t     prod_o
);

  tti_pkg::prod_t prod_d, prod_q;
  logic           prod_valid_q;

  always_comb begin
    prod_d.num = tti_pkg::NUM_W'(seg_i.dt) * tti_pkg::NUM_W'(seg_i.dx)
               + tti_pkg::NUM_W'(seg_i.da >> 1);
    prod_d.da  = seg_i.da;
    prod_d.t0  = seg_i.t0;
    prod_d.oor = seg_i.oor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (advance_i) begin
      prod_valid_q <= seg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_valid_q;
  assign prod_o       = prod_q;

endmodule

`default_nettype wire

>>> hdl/tti_div_pipe.sv
// ----------------------------------------------------------------------------
// tti_div_pipe
// Restoring divider, one quotient bit per registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_div_pipe (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           advance_i,
  input  wire logic           prod_valid_i,
  input  wire tti_pkg::prod_t prod_i,
  output logic                quot_valid_o,
  output tti_pkg::quot_t      quot_o
);

  localparam int STAGES = tti_pkg::TEMP_W;

  logic [tti_pkg::NUM_W-1:0]  rem_d [STAGES];
  logic [tti_pkg::NUM_W-1:0]  rem_q [STAGES];
  logic [tti_pkg::TEMP_W-1:0] quo_d [STAGES];
  logic [tti_pkg::TEMP_W-1:0] quo_q [STAGES];
  logic [tti_pkg::ADC_W-1:0]  da_q  [STAGES];
  logic [tti_pkg::TEMP_W-1:0] t0_q  [STAGES];
  logic                       oor_q [STAGES];
  logic [STAGES-1:0]          vld_q;

  always_comb begin
    logic [tti_pkg::NUM_W-1:0]  rem_src;
    logic [tti_pkg::NUM_W-1:0]  dsh;
    logic [tti_pkg::TEMP_W-1:0] quo_src;
    logic [tti_pkg::ADC_W-1:0]  da_src;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        rem_src = prod_i.num;
        quo_src = '0;
        da_src  = prod_i.da;
      end else begin
        rem_src = rem_q[s-1];
        quo_src = quo_q[s-1];
        da_src  = da_q[s-1];
      end
      dsh      = tti_pkg::NUM_W'(da_src) << (STAGES - 1 - s);
      quo_d[s] = quo_src;
      if (rem_src >= dsh) begin
        rem_d[s]                 = rem_src - dsh;
        quo_d[s][STAGES - 1 - s] = 1'b1;
      end else begin
        rem_d[s] = rem_src;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance_i) begin
      vld_q <= {vld_q[STAGES-2:0], prod_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int s = 0; s < STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        if (s == 0) begin
          da_q[s]  <= prod_i.da;
          t0_q[s]  <= prod_i.t0;
          oor_q[s] <= prod_i.oor;
        end else begin
          da_q[s]  <= da_q[s-1];
          t0_q[s]  <= t0_q[s-1];
          oor_q[s] <= oor_q[s-1];
        end
      end
    end
  end

  assign quot_valid_o = vld_q[STAGES-1];
  assign quot_o.quo   = quo_q[STAGES-1];
  assign quot_o.t0    = t0_q[STAGES-1];
  assign quot_o.oor   = oor_q[STAGES-1];

endmodule

`default_nettype wire

>>> tb/sv/thermistor_table_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_tb
// Self-checking bench for the thermistor table interpolator. Each request
// accepted from the sample queue gets its temperature and clamp flag worked
// out from the breakpoint ROM. Every result is then checked in order against
// that prediction. Traffic runs through phases with sender gaps, receiver
// stalls and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_table_interpolator_tb;

  // Points of the ROM in use with the default parameter, never fewer than two.
  localparam int POINTS_IN_USE =
    (tti_pkg::DEFAULT_TABLE_ENTRIES < tti_pkg::ROM_POINTS) ? tti_pkg::DEFAULT_TABLE_ENTRIES
                                                           : tti_pkg::ROM_POINTS;
  localparam int SEARCH_POINTS = (POINTS_IN_USE < 2) ? 2 : POINTS_IN_USE;

  localparam int PIPE_LATENCY   = 20;
  localparam int DRAIN_CYCLES   = 4 * PIPE_LATENCY;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int PRESSURE_REQUESTS = 100;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [tti_pkg::TEMP_W-1:0] temperature;
    logic                       clamped;
  } reading_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [tti_pkg::ADC_W-1:0]  adc_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [tti_pkg::TEMP_W-1:0] temperature_q8_8_o;
  logic                       out_of_range_o;

  logic [tti_pkg::ADC_W-1:0] pending_samples[$];
  reading_t                  expected_readings[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  bit hold_arm       = 1'b0;

  // Directed corners: both ends, just inside and outside the table, exact
  // breakpoints and interpolated points.
  int corner_samples[] = '{
    0, 1023, 249, 250, 251, 1000, 1001, 999, 784, 783, 785, 937, 936,
    975, 976, 262, 263, 341, 682, 512, 775, 826
  };
  int idle_mix[4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{18, 18}};

  thermistor_table_interpolator u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_sample_i       (adc_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .temperature_q8_8_o (temperature_q8_8_o),
    .out_of_range_o     (out_of_range_o)
  );

  always #5 clk_i = ~clk_i;

  // Piecewise linear lookup: clamp outside the table, return the breakpoint
  // temperature on an exact hit, else interpolate across the bracketing
  // segment, rounding to nearest with halves going up.
  function automatic reading_t interpolate_temperature(logic [tti_pkg::ADC_W-1:0] sample);
    reading_t    reading;
    int unsigned x;
    int unsigned a0;
    int unsigned span;
    int unsigned rise;
    x = 32'(sample);
    reading.clamped = 1'b0;
    reading.temperature = tti_pkg::ROM_TEMP[0];
    if (x < 32'(tti_pkg::ROM_ADC[0])) begin
      reading.clamped = 1'b1;
    end else if (x > 32'(tti_pkg::ROM_ADC[SEARCH_POINTS-1])) begin
      reading.temperature = tti_pkg::ROM_TEMP[SEARCH_POINTS-1];
      reading.clamped = 1'b1;
    end else begin
      for (int i = 0; i < SEARCH_POINTS; i++) begin
        if (x == 32'(tti_pkg::ROM_ADC[i])) begin
          reading.temperature = tti_pkg::ROM_TEMP[i];
          break;
        end
        if (x < 32'(tti_pkg::ROM_ADC[i])) begin
          a0   = 32'(tti_pkg::ROM_ADC[i-1]);
          span = 32'(tti_pkg::ROM_ADC[i]) - a0;
          rise = 32'(tti_pkg::ROM_TEMP[i]) - 32'(tti_pkg::ROM_TEMP[i-1]);
          reading.temperature = tti_pkg::TEMP_W'(32'(tti_pkg::ROM_TEMP[i-1])
                              + (rise * (x - a0) + span / 2) / span);
          break;
        end
      end
    end
    return reading;
  endfunction

  // Mostly uniform codes, with a good share near breakpoints and beyond
  // either end of the table so clamping and exact hits come up often.
  function automatic logic [tti_pkg::ADC_W-1:0] random_sample();
    int code;
    case ($urandom_range(9))
      0, 1: begin
        code = int'(tti_pkg::ROM_ADC[$urandom_range(tti_pkg::ROM_POINTS-1)])
             + int'($urandom_range(2)) - 1;
      end
      2: begin
        code = $urandom_range(1)
             ? int'($urandom_range(tti_pkg::ROM_ADC[0]-1))
             : int'($urandom_range(1023, tti_pkg::ROM_ADC[tti_pkg::ROM_POINTS-1] + 1));
      end
      default: code = int'($urandom_range(1023));
    endcase
    return code[tti_pkg::ADC_W-1:0];
  endfunction

  // Sender: present the head of the sample queue, hold it while stalled,
  // and log the prediction once the request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      adc_sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_readings.push_back(interpolate_temperature(adc_sample_i));
        void'(pending_samples.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled request as it is
      end else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        adc_sample_i <= pending_samples[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long hold-off: count down in its own process once armed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_OFF_CYCLES;
    end
  end

  // Receiver: stall at random, and solidly during a hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Result check: compare each taken result with the oldest prediction.
  always @(posedge clk_i) begin
    reading_t wanted;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result: temperature %0d out_of_range %0d",
                   temperature_q8_8_o, out_of_range_o);
      end else begin
        wanted = expected_readings.pop_front();
        if (temperature_q8_8_o !== wanted.temperature ||
            out_of_range_o !== wanted.clamped) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch: temperature exp %0d got %0d, out_of_range exp %0d got %0d",
                     wanted.temperature, temperature_q8_8_o,
                     wanted.clamped, out_of_range_o);
        end
      end
    end
  end

  // Watchdog: give up if the run stalls for good.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("thermistor_table_interpolator_tb failed");
      $finish;
    end
  end

  task automatic wait_for_drain();
    while (pending_samples.size() != 0 || expected_readings.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic queue_random(int count);
    for (int n = 0; n < count; n++)
      pending_samples.push_back(random_sample());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners first, with no idling.
    foreach (corner_samples[k])
      pending_samples.push_back(corner_samples[k][tti_pkg::ADC_W-1:0]);
    wait_for_drain();

    // Random traffic under each idling mix; drain between phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p][0];
      stall_pct     = idle_mix[p][1];
      queue_random(RANDOM_PER_PHASE);
      wait_for_drain();
    end

    // Back-pressure: hold the receiver off while the sender keeps offering,
    // so the pipeline fills and stalls its input.
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random(PRESSURE_REQUESTS);
    hold_arm = 1'b1;
    while (hold_left == 0) @(negedge clk_i);
    hold_arm = 1'b0;
    wait_for_drain();

    // Let any stray result show up before judging.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("thermistor_table_interpolator_tb passed");
    end else begin
      $display("thermistor_table_interpolator_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> thermistor_table_interpolator.f
hdl/tti_pkg.sv
hdl/tti_seg_search.sv
hdl/tti_interp_mul.sv
hdl/tti_div_pipe.sv
hdl/thermistor_table_interpolator.sv
tb/sv/thermistor_table_interpolator_tb.sv
